// ===== hdl/vlpe_pkg.sv =====
// Package for the length-prefixed varint encoder.
// Holds width codes and byte constants; depends on nothing.
`default_nettype none
package vlpe_pkg;

   localparam logic [1:0] WIDTH_1B = 2'd0;
   localparam logic [1:0] WIDTH_2B = 2'd1;
   localparam logic [1:0] WIDTH_4B = 2'd2;
   localparam logic [1:0] WIDTH_8B = 2'd3;

   localparam logic [7:0] SHORT_LIMIT = 8'h80;
   localparam int         GROUPS      = 8;

endpackage
`default_nettype wire

// ===== hdl/varint_length_prefixed_encoder_unit.sv =====
// Top level of the length-prefixed varint encoder.
// Uses vlpe_pkg for width codes and constants.
//
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | req_value[63:0], req_width_code[1:0]
// rsp     | out       | rsp_valid/rsp_ready  | rsp_out_byte[7:0], rsp_last
//
// Each item yields 1 to 9 bytes, one byte per cycle into the output register while
// rsp is not stalled, so an item occupies the encoder until its last byte is loaded.
// The next item is taken in the cycle its predecessor's last byte is loaded.
// Reset (synchronous) empties the holding and output registers.
// A stalled rsp channel holds the output byte and stops the byte sequence.
`default_nettype none
module varint_length_prefixed_encoder_unit
   import vlpe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_value,
   input  wire logic [1:0]  req_width_code,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last
);

   logic        hold_valid_ff, hold_valid_in;
   logic [63:0] data_ff, data_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [3:0]  idx_ff, idx_in;
   logic        short_ff, short_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;

   logic [63:0] masked;
   logic [63:0] groups;
   logic [3:0]  s_calc;
   logic        is_short;
   logic        out_free;
   logic        emit;
   logic        emit_last;
   logic        accept;
   logic [2:0]  len_field;
   logic [7:0]  cur_byte;

   always_comb begin
      case (req_width_code)
         WIDTH_1B: masked = {56'd0, req_value[7:0]};
         WIDTH_2B: masked = {48'd0, req_value[15:0]};
         WIDTH_4B: masked = {32'd0, req_value[31:0]};
         WIDTH_8B: masked = req_value;
         default:  masked = req_value;
      endcase
   end

   assign is_short = (req_width_code == WIDTH_1B) || (masked < {56'd0, SHORT_LIMIT});
   assign groups   = {4'd0, masked[63:4]};

   always_comb begin
      s_calc = 4'd0;
      for (int j = 0; j < GROUPS; j++) begin
         if (groups[8*j +: 8] != 8'd0) begin
            s_calc = 4'(j + 1);
         end
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = hold_valid_ff && out_free;
   assign emit_last = (idx_ff == cnt_ff);
   assign req_ready = !hold_valid_ff || (emit && emit_last);
   assign accept    = req_valid && req_ready;

   assign len_field = 3'(cnt_ff - 4'd1);

   always_comb begin
      if (idx_ff == 4'd0 && !short_ff) begin
         cur_byte = {1'b1, len_field, data_ff[3:0]};
      end else begin
         cur_byte = data_ff[7:0];
      end
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      data_in       = data_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      short_in      = short_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      byte_in       = byte_ff;
      last_in       = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         byte_in      = cur_byte;
         last_in      = emit_last;
         idx_in       = idx_ff + 4'd1;
         if (idx_ff == 4'd0) begin
            data_in = data_ff >> 4;
         end else begin
            data_in = data_ff >> 8;
         end
         if (emit_last) begin
            hold_valid_in = 1'b0;
         end
      end
      if (accept) begin
         hold_valid_in = 1'b1;
         data_in       = masked;
         cnt_in        = is_short ? 4'd0 : s_calc;
         idx_in        = 4'd0;
         short_in      = is_short;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      data_ff  <= data_in;
      cnt_ff   <= cnt_in;
      idx_ff   <= idx_in;
      short_ff <= short_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;

`ifndef SYNTHESIS
   a_accept_holds : assert property (@(posedge clock) disable iff (reset)
      accept |=> hold_valid_ff)
      else $error("Accepted item was not captured.");

   a_idx_bound : assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> (idx_ff <= cnt_ff) && (cnt_ff <= 4'd8))
      else $error("Byte index ran past the item's length.");

   a_short_single : assert property (@(posedge clock) disable iff (reset)
      (hold_valid_ff && short_ff) |-> (cnt_ff == 4'd0))
      else $error("Short item has more than one byte.");

   a_last_frees : assert property (@(posedge clock) disable iff (reset)
      (emit && emit_last && !accept) |=> !hold_valid_ff)
      else $error("Holding register stayed busy after the last byte.");
`endif

endmodule
`default_nettype wire

// ===== test/vlpe_checker.sv =====
`timescale 1ns / 100ps
// Checker for the length-prefixed varint encoder: predicts the byte stream of each
// accepted item and compares every accepted output byte with the oldest prediction.
// Depends on vlpe_pkg for the width codes and byte constants.
module vlpe_checker
   import vlpe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [63:0] req_value,
   input  wire logic [1:0]  req_width_code,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [7:0]  rsp_out_byte,
   input  wire logic        rsp_last,
   output int               error_count,
   output int               pending_count
);

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } coded_byte_type;

   coded_byte_type expected_bytes[$];
   coded_byte_type want;

   function automatic logic [63:0] mask_to_source(logic [63:0] value, logic [1:0] code);
      case (code)
         WIDTH_1B: return value & 64'h0000_0000_0000_00FF;
         WIDTH_2B: return value & 64'h0000_0000_0000_FFFF;
         WIDTH_4B: return value & 64'h0000_0000_FFFF_FFFF;
         default: return value;
      endcase
   endfunction

   task automatic predict_encoding(input logic [63:0] value, input logic [1:0] code);
      logic [63:0]    u;
      int             bits;
      int             extra;
      coded_byte_type b;
      u = mask_to_source(value, code);
      if (code == WIDTH_1B || u < 64'(SHORT_LIMIT)) begin
         b.data = u[7:0];
         b.last = 1'b1;
         expected_bytes.push_back(b);
      end else begin
         bits = 0;
         for (int i = 0; i < 64; i++) begin
            if (u[i]) bits = i + 1;
         end
         extra = (bits + 3) / GROUPS;
         b.data = SHORT_LIMIT | 8'((extra - 1) << 4) | {4'h0, u[3:0]};
         b.last = 1'b0;
         expected_bytes.push_back(b);
         for (int k = 0; k < extra; k++) begin
            b.data = 8'(u >> (4 + GROUPS * k));
            b.last = (k == extra - 1);
            expected_bytes.push_back(b);
         end
      end
   endtask

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) predict_encoding(req_value, req_width_code);
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               error_count = error_count + 1;
               $display("%0t: unexpected byte, expected none, actual data %02h last %0b",
                        $time, rsp_out_byte, rsp_last);
            end else begin
               want = expected_bytes.pop_front();
               if (want.data !== rsp_out_byte || want.last !== rsp_last) begin
                  error_count = error_count + 1;
                  $display({"%0t: byte mismatch, expected data %02h last %0b, ",
                            "actual data %02h last %0b"},
                           $time, want.data, want.last, rsp_out_byte, rsp_last);
               end
            end
         end
         pending_count = expected_bytes.size();
      end
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the length-prefixed varint encoder: clock, reset, stimulus with
// idling and back-pressure, verdict. Depends on vlpe_pkg, vlpe_checker, the encoder.
module tb
   import vlpe_pkg::*;
();

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_value;
   logic [1:0]  req_width_code;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;

   int failures;
   int pending;
   int tx_gap_pct   = 0;
   int rx_stall_pct = 0;
   int hold_left    = 0;
   int cycles       = 0;
   bit hold_req     = 1'b0;

   varint_length_prefixed_encoder_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .req_width_code (req_width_code),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last)
   );

   vlpe_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .req_width_code (req_width_code),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last),
      .error_count    (failures),
      .pending_count  (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[varint_length_prefixed_encoder_unit] ERROR");
      $finish;
   end

   // The receiver owns its hold-off count; a request is raised at a rising edge.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   task automatic send_item(input logic [63:0] value, input logic [1:0] code);
      while ($urandom_range(99) < tx_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_value      <= value;
      req_width_code <= code;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random_items(input int count);
      logic [63:0] v;
      logic [1:0]  c;
      int          maxlen;
      int          len;
      repeat (count) begin
         c = 2'($urandom_range(3));
         v = {$urandom, $urandom};
         if ($urandom_range(99) >= 30) begin
            case (c)
               WIDTH_1B: maxlen = 8;
               WIDTH_2B: maxlen = 16;
               WIDTH_4B: maxlen = 32;
               default: maxlen = 64;
            endcase
            len = $urandom_range(maxlen);
            if (len < 64) v = v & ((64'd1 << len) - 64'd1);
            if (len > 0) v[len - 1] = 1'b1;
            if (maxlen < 64 && $urandom_range(3) == 0) v = v | ({$urandom, $urandom} << maxlen);
         end
         send_item(v, c);
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_value      = '0;
      req_width_code = WIDTH_1B;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      send_item(64'h0000_0000_0000_0000, WIDTH_1B);
      send_item(64'h0000_0000_0000_00FF, WIDTH_1B);
      send_item(64'hFFFF_FFFF_FFFF_FFAB, WIDTH_1B);
      send_item(64'h0000_0000_0000_007F, WIDTH_2B);
      send_item(64'h0000_0000_0000_0080, WIDTH_2B);
      send_item(64'h0000_0000_0000_07FF, WIDTH_2B);
      send_item(64'h0000_0000_0000_0800, WIDTH_2B);
      send_item(64'h0000_0000_0000_1000, WIDTH_2B);
      send_item(64'h0000_0000_0000_FFFF, WIDTH_2B);
      send_item(64'hFFFF_FFFF_FFFF_0012, WIDTH_2B);
      send_item(64'h0000_0000_0000_0000, WIDTH_4B);
      send_item(64'h0000_0001_0000_0000, WIDTH_4B);
      send_item(64'h0000_0000_FFFF_FFFF, WIDTH_4B);
      send_item(64'hA5A5_A5A5_8000_0000, WIDTH_4B);
      send_item(64'h0000_0000_0000_007F, WIDTH_8B);
      send_item(64'h0000_0000_0000_0080, WIDTH_8B);
      send_item(64'hFFFF_FFFF_FFFF_FFFF, WIDTH_8B);
      send_item(64'h8000_0000_0000_0000, WIDTH_8B);
      send_item(64'h0FFF_FFFF_FFFF_FFFF, WIDTH_8B);
      send_item(64'h1000_0000_0000_0000, WIDTH_8B);

      // Long receiver hold-off while items keep coming, so the input stalls.
      req_valid <= 1'b0;
      @(posedge clock);
      hold_req = 1'b1;
      @(negedge clock);
      send_random_items(12);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               tx_gap_pct   = 0;
               rx_stall_pct = 0;
            end
            1: begin
               tx_gap_pct   = 54;
               rx_stall_pct = 0;
            end
            2: begin
               tx_gap_pct   = 0;
               rx_stall_pct = 54;
            end
            default: begin
               tx_gap_pct   = 23;
               rx_stall_pct = 23;
            end
         endcase
         send_random_items(25);
      end
      req_valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (failures == 0) begin
         $display("[varint_length_prefixed_encoder_unit] OK");
      end else begin
         $display("[varint_length_prefixed_encoder_unit] ERROR");
      end
      $finish;
   end

endmodule
